// ===== design/kwc_pkg.sv =====
// Package: sizes, types and base-coding function for the k-mer window counter.
`default_nettype none

package kwc_pkg;

    localparam int MAX_K      = 8;
    localparam int COUNT_BITS = 32;
    localparam int CODE_BITS  = 2 * MAX_K;
    localparam int SEEN_BITS  = $clog2(MAX_K + 1);

    typedef logic [CODE_BITS-1:0]  code_t;
    typedef logic [COUNT_BITS-1:0] count_t;
    typedef logic [SEEN_BITS-1:0]  seen_t;
    typedef logic [3:0]            klen_t;
    typedef logic [1:0]            base_t;

    localparam klen_t  KLEN_RESET = 4'd8;
    localparam count_t COUNT_MAX  = '1;
    localparam code_t  CODE_LAST  = '1;

    localparam logic [7:0] CHAR_UC_C = 8'h43;
    localparam logic [7:0] CHAR_UC_G = 8'h47;
    localparam logic [7:0] CHAR_UC_T = 8'h54;
    localparam logic [7:0] CHAR_LC_C = 8'h63;
    localparam logic [7:0] CHAR_LC_G = 8'h67;
    localparam logic [7:0] CHAR_LC_T = 8'h74;

    localparam base_t BASE_A = 2'd0;
    localparam base_t BASE_C = 2'd1;
    localparam base_t BASE_G = 2'd2;
    localparam base_t BASE_T = 2'd3;

    // Table access decided at the input stage
    typedef struct packed {
        logic  hit;    // push that completes a k-mer
        logic  query;  // read request
        code_t addr;
    } kwc_lookup_t;

    function automatic base_t base_code(input logic [7:0] ch);
        base_t code;
        unique case (ch)
            CHAR_UC_C, CHAR_LC_C: code = BASE_C;
            CHAR_UC_G, CHAR_LC_G: code = BASE_G;
            CHAR_UC_T, CHAR_LC_T: code = BASE_T;
            default:              code = BASE_A;
        endcase
        return code;
    endfunction

endpackage

`default_nettype wire

// ===== design/kwc_if.sv =====
// Interfaces: request and response channels of the k-mer window counter.
`default_nettype none

interface kwc_req_if;
    logic        valid;
    logic        ready;
    logic        req_type;
    logic [7:0]  base_char;
    logic        read_start;
    logic [15:0] query_index;

    modport source (output valid, req_type, base_char, read_start, query_index, input ready);
    modport sink   (input valid, req_type, base_char, read_start, query_index, output ready);
endinterface

interface kwc_rsp_if;
    logic        valid;
    logic        ready;
    logic        window_full;
    logic [15:0] kmer_code;
    logic [31:0] kmer_count;

    modport source (output valid, window_full, kmer_code, kmer_count, input ready);
    modport sink   (input valid, window_full, kmer_code, kmer_count, output ready);
endinterface

`default_nettype wire

// ===== design/kwc_window.sv =====
// Window stage: k register, base window, fill count and table address selection.
`default_nettype none

module kwc_window (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cfg_we,
    input  wire logic [3:0]          cfg_wdata,
    input  wire logic                accept,
    input  wire logic                req_type,
    input  wire logic [7:0]          base_char,
    input  wire logic                read_start,
    input  wire logic [15:0]         query_index,
    output kwc_pkg::kwc_lookup_t     lookup
);
    import kwc_pkg::*;

    klen_t klen_reg;
    code_t window_reg, window_next;
    seen_t seen_reg, seen_next;
    seen_t eff_k;
    code_t window_base;
    seen_t seen_base;
    code_t kmask;

    always_comb
    begin
        if (klen_reg == 4'd0)
        begin
            eff_k = seen_t'(1);
        end
        else if (klen_reg > MAX_K)
        begin
            eff_k = seen_t'(MAX_K);
        end
        else
        begin
            eff_k = seen_t'(klen_reg);
        end

        for (int i = 0; i < MAX_K; i++)
        begin
            kmask[2*i +: 2] = (i < int'(eff_k)) ? 2'b11 : 2'b00;
        end

        window_base = read_start ? '0 : window_reg;
        seen_base   = read_start ? '0 : seen_reg;
        window_next = CODE_BITS'({window_base, base_code(base_char)});
        seen_next   = (seen_base < MAX_K) ? seen_base + seen_t'(1) : seen_base;

        lookup.query = req_type;
        lookup.hit   = !req_type && (seen_next >= eff_k);
        lookup.addr  = req_type ? CODE_BITS'(query_index) : (window_next & kmask);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            klen_reg   <= KLEN_RESET;
            window_reg <= '0;
            seen_reg   <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                klen_reg <= cfg_wdata;
            end
            if (accept && !req_type)
            begin
                window_reg <= window_next;
                seen_reg   <= seen_next;
            end
        end
    end

endmodule

`default_nettype wire

// ===== design/kmer_window_counter.sv =====
// Top level: k-mer window counter with count table memory and response register.
//
// Usage:
//   req carries one request per handshake: req_type 0 pushes base_char (with
//   read_start marking the first base of a read), req_type 1 reads the count
//   stored at query_index. Each request gives exactly one response on rsp:
//   window_full, kmer_code and kmer_count. cfg_we/cfg_wdata write k while idle.
//   Response: a taken request passes the memory stage, then the response register.
//   Throughput: one request per cycle while rsp is ready and no table sweep runs;
//   the count table is read at the input stage and written from the memory
//   stage, a forwarding register covers back-to-back updates of the same k-mer.
//   Reset: k returns to 8, the window empties and a sweep zeroes the 65536
//   table entries one per cycle; req.ready stays low until the sweep ends.
//   Stall: the response register holds while rsp.ready is low; one more
//   request waits in the memory stage, then req.ready drops until rsp drains.
`default_nettype none

module kmer_window_counter (
    input  wire logic       clk,
    input  wire logic       rst_n,
    kwc_req_if.sink         req,
    kwc_rsp_if.source       rsp,
    input  wire logic       cfg_we,
    input  wire logic [3:0] cfg_wdata
);
    import kwc_pkg::*;

    count_t table_mem [2**CODE_BITS];

    kwc_lookup_t lookup;
    logic        accept;
    logic        adv;

    logic   clr_active_reg, clr_active_next;
    code_t  clr_addr_reg, clr_addr_next;

    logic   s1_valid_reg, s1_valid_next;
    logic   s1_hit_reg;
    logic   s1_query_reg;
    code_t  s1_addr_reg;
    count_t rd_data_reg;

    logic   fwd_valid_reg;
    code_t  fwd_addr_reg;
    count_t fwd_data_reg;

    count_t cur_count;
    count_t upd_count;
    logic   cnt_we;
    logic   wr_en;
    code_t  wr_addr;
    count_t wr_data;

    logic        out_valid_reg;
    logic        out_full_reg, out_full_next;
    logic [15:0] out_code_reg, out_code_next;
    logic [31:0] out_count_reg, out_count_next;

    assign adv       = !out_valid_reg || rsp.ready;
    assign req.ready = !clr_active_reg && (!s1_valid_reg || adv);
    assign accept    = req.valid && req.ready;

    kwc_window u_window (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .accept      (accept),
        .req_type    (req.req_type),
        .base_char   (req.base_char),
        .read_start  (req.read_start),
        .query_index (req.query_index),
        .lookup      (lookup)
    );

    always_comb
    begin
        cur_count = (fwd_valid_reg && fwd_addr_reg == s1_addr_reg) ? fwd_data_reg : rd_data_reg;
        upd_count = (cur_count == COUNT_MAX) ? cur_count : cur_count + count_t'(1);
        cnt_we    = s1_valid_reg && adv && s1_hit_reg;

        wr_en   = clr_active_reg || cnt_we;
        wr_addr = clr_active_reg ? clr_addr_reg : s1_addr_reg;
        wr_data = clr_active_reg ? '0 : upd_count;

        clr_addr_next   = clr_addr_reg + code_t'(1);
        clr_active_next = clr_active_reg && (clr_addr_reg != CODE_LAST);

        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (adv)
        begin
            s1_valid_next = 1'b0;
        end
        else
        begin
            s1_valid_next = s1_valid_reg;
        end

        if (s1_query_reg)
        begin
            out_full_next  = 1'b1;
            out_code_next  = 16'(s1_addr_reg);
            out_count_next = 32'(cur_count);
        end
        else if (s1_hit_reg)
        begin
            out_full_next  = 1'b1;
            out_code_next  = 16'(s1_addr_reg);
            out_count_next = 32'(upd_count);
        end
        else
        begin
            out_full_next  = 1'b0;
            out_code_next  = '0;
            out_count_next = '0;
        end
    end

    // Count table: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            table_mem[wr_addr] <= wr_data;
        end
        if (accept)
        begin
            rd_data_reg <= table_mem[lookup.addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_active_reg <= 1'b1;
            clr_addr_reg   <= '0;
            s1_valid_reg   <= 1'b0;
            fwd_valid_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (clr_active_reg)
            begin
                clr_addr_reg <= clr_addr_next;
            end
            clr_active_reg <= clr_active_next;
            s1_valid_reg   <= s1_valid_next;
            if (cnt_we)
            begin
                fwd_valid_reg <= 1'b1;
            end
            if (adv)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_hit_reg   <= lookup.hit;
            s1_query_reg <= lookup.query;
            s1_addr_reg  <= lookup.addr;
        end
        if (cnt_we)
        begin
            fwd_addr_reg <= s1_addr_reg;
            fwd_data_reg <= upd_count;
        end
        if (adv && s1_valid_reg)
        begin
            out_full_reg  <= out_full_next;
            out_code_reg  <= out_code_next;
            out_count_reg <= out_count_next;
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.window_full = out_full_reg;
    assign rsp.kmer_code   = out_code_reg;
    assign rsp.kmer_count  = out_count_reg;

    // No request in flight while the table sweep runs
    a_sweep_empty: assert property (@(posedge clk) disable iff (!rst_n)
        clr_active_reg |-> !s1_valid_reg && !out_valid_reg)
        else $error("request in flight during table sweep");

    // A counted k-mer is never written back as zero
    a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_we |-> upd_count != '0)
        else $error("counted entry written as zero");

    // An incomplete window reports all zeros
    a_empty_rsp: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && !rsp.window_full) |-> (rsp.kmer_code == '0 && rsp.kmer_count == '0))
        else $error("nonzero response for incomplete window");

    // A query leaves the table untouched
    a_query_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && s1_query_reg) |-> !cnt_we)
        else $error("table written by a read request");

endmodule

`default_nettype wire
